// ===== src/trie_transition_builder_core_macros.svh =====
// Assertion macros used by the trie builder core RTL.
// Included by files that carry concurrent checks; needs no package.
`ifndef TRIE_TRANSITION_BUILDER_CORE_MACROS_SVH
`define TRIE_TRANSITION_BUILDER_CORE_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define TTB_ASSERT_IMPLY(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("trie builder check failed");

// Check that a condition implies a consequence in the next cycle.
`define TTB_ASSERT_NEXT(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("trie builder check failed");

`endif

// ===== src/ttb_pkg.sv =====
// Shared types and constants for the trie transition builder.
// No dependencies; used by the edge store, the top level, the checker and the testbench.
`timescale 1ns / 1ps

package ttb_pkg;

  // Default sizes of the edge table
  localparam int MAX_STATES_DEF = 1024;
  localparam int ALPHABET_DEF   = 256;

  // Field widths
  localparam int SYM_W   = 8;
  localparam int STATE_W = 10;
  localparam int FREE_W  = 11;
  localparam int CFG_IDX_W = 2;

  // Saturation value of the next-free counter
  localparam logic [FREE_W-1:0] FREE_MAX = 11'h7FF;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT_STATE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FREE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STATE_LIMIT = 2'd2;

  typedef struct packed {
    logic [SYM_W-1:0]   symbol;
    logic [STATE_W-1:0] pattern_id;
    logic               last_symbol;
  } item_t;

  typedef struct packed {
    logic [STATE_W-1:0] from_state;
    logic [STATE_W-1:0] to_state;
    logic               allocated;
    logic [FREE_W-1:0]  used_states;
    logic               overflow;
  } result_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK
  } fsm_t;

  // Edge store commands: lookup read, edge write-back, row clear
  typedef struct packed {
    logic rd;
    logic wr_edge;
    logic clr;
  } mem_cmd_t;

endpackage

// ===== src/ttb_edge_store.sv =====
// Edge table storage: valid rows (one bit per symbol) and edge targets.
// Depends on ttb_pkg for the command struct and state width.
`timescale 1ns / 1ps

module ttb_edge_store #(
  parameter int MAX_STATES = ttb_pkg::MAX_STATES_DEF,
  parameter int ALPHABET   = ttb_pkg::ALPHABET_DEF,
  localparam int ROW_W     = $clog2(MAX_STATES),
  localparam int COL_W     = $clog2(ALPHABET)
) (
  input  logic                        clk,
  input  ttb_pkg::mem_cmd_t           cmd,
  input  logic [ROW_W-1:0]            rd_row,
  input  logic [COL_W-1:0]            rd_col,
  input  logic [ROW_W-1:0]            clr_row,
  input  logic [ttb_pkg::STATE_W-1:0] wr_target,
  output logic                        hit,
  output logic [ttb_pkg::STATE_W-1:0] target
);

  localparam int TGT_DEPTH = MAX_STATES << COL_W;

  logic [ALPHABET-1:0]         valid_mem [MAX_STATES];
  logic [ttb_pkg::STATE_W-1:0] tgt_mem   [TGT_DEPTH];

  logic [ALPHABET-1:0] vrow;
  logic [ROW_W-1:0]    row_q;
  logic [COL_W-1:0]    col_q;

  // Read the valid row and target; hold the address for the write-back
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      vrow   <= valid_mem[rd_row];
      target <= tgt_mem[{rd_row, rd_col}];
      row_q  <= rd_row;
      col_q  <= rd_col;
    end
  end

  // Clear a whole valid row, or set one mark and store its target
  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      valid_mem[clr_row] <= '0;
    end else if (cmd.wr_edge) begin
      valid_mem[row_q]         <= vrow | (ALPHABET'(1) << col_q);
      tgt_mem[{row_q, col_q}] <= wr_target;
    end
  end

  assign hit = vrow[col_q];

endmodule

// ===== src/trie_transition_builder_core.sv =====
// Trie transition builder: goto-table construction, one pattern byte a beat.
// Path: the edge store registers the lookup read, then the LOOK state
// registers the result and its done strobe. A new item is taken only back in
// IDLE, with busy high meanwhile. Results are never stalled by the receiver.
// Reset: a clearing pass wipes one valid row per cycle, MAX_STATES rows
// (1024 by default), with busy high; configuration writes are taken meanwhile.
`timescale 1ns / 1ps
`include "trie_transition_builder_core_macros.svh"

module trie_transition_builder_core #(
  parameter int MAX_STATES = ttb_pkg::MAX_STATES_DEF,
  parameter int ALPHABET   = ttb_pkg::ALPHABET_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  ttb_pkg::item_t                 item,
  output logic                           done,
  output ttb_pkg::result_t               result,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ttb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ttb_pkg::FREE_W-1:0]     cfg_data
);

  localparam int ROW_W = $clog2(MAX_STATES);
  localparam int COL_W = $clog2(ALPHABET);

  ttb_pkg::fsm_t state, state_next;
  ttb_pkg::mem_cmd_t cmd;

  logic [ROW_W-1:0] clr_row;
  logic             clr_last;
  logic             accept;

  // Configuration registers
  logic [ttb_pkg::STATE_W-1:0] root_state;
  logic [ttb_pkg::FREE_W-1:0]  first_free_state;
  logic [ttb_pkg::FREE_W-1:0]  state_limit;

  // Walk state
  logic [ttb_pkg::STATE_W-1:0] walk_state, walk_state_next;
  logic                        at_root, at_root_next;
  logic [ttb_pkg::FREE_W-1:0]  next_free, next_free_next;
  logic                        started;
  logic                        ovf, ovf_next;

  // Item held across the lookup
  logic [ttb_pkg::SYM_W-1:0]   sym_q;
  logic [ttb_pkg::STATE_W-1:0] pid_q;
  logic                        last_q;
  logic [ttb_pkg::STATE_W-1:0] cur_q;
  logic [ttb_pkg::FREE_W-1:0]  nf_q;

  logic [ttb_pkg::STATE_W-1:0] cur_acc;
  logic [ttb_pkg::FREE_W-1:0]  nf_acc;

  // Lookup results and edge decision
  logic                        hit;
  logic [ttb_pkg::STATE_W-1:0] target;
  logic [ttb_pkg::STATE_W-1:0] wr_target;
  logic                        write_edge;
  logic [ttb_pkg::STATE_W-1:0] to_v;
  logic                        alloc_v;
  logic [ttb_pkg::FREE_W:0]    grown;
  logic                        sym_ok;
  logic                        in_range;

  // Refuse register beats while an item is being taken or looked up
  assign cfg_ready = (state != ttb_pkg::ST_LOOK) && !accept;
  assign accept    = start && !busy;
  assign clr_last  = (clr_row == ROW_W'(MAX_STATES - 1));

  // Take configuration beats
  always_ff @(posedge clk) begin
    if (rst) begin
      root_state       <= '0;
      first_free_state <= 11'd1;
      state_limit      <= 11'd1024;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ttb_pkg::CFG_ROOT_STATE:  root_state       <= cfg_data[ttb_pkg::STATE_W-1:0];
        ttb_pkg::CFG_FIRST_FREE:  first_free_state <= cfg_data;
        ttb_pkg::CFG_STATE_LIMIT: state_limit      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ttb_pkg::ST_CLEAR: if (clr_last) state_next = ttb_pkg::ST_IDLE;
      ttb_pkg::ST_IDLE:  if (start) state_next = ttb_pkg::ST_LOOK;
      ttb_pkg::ST_LOOK:  state_next = ttb_pkg::ST_IDLE;
      default:           state_next = ttb_pkg::ST_CLEAR;
    endcase
  end

  // State outputs
  always_comb begin
    busy        = 1'b1;
    cmd.rd      = 1'b0;
    cmd.wr_edge = 1'b0;
    cmd.clr     = 1'b0;
    case (state)
      ttb_pkg::ST_CLEAR: cmd.clr = 1'b1;
      ttb_pkg::ST_IDLE: begin
        busy   = 1'b0;
        cmd.rd = start;
      end
      ttb_pkg::ST_LOOK:  cmd.wr_edge = write_edge;
      default: ;
    endcase
  end

  // Advance the state register and the clearing sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ttb_pkg::ST_CLEAR;
      clr_row <= '0;
    end else begin
      state <= state_next;
      if (cmd.clr) clr_row <= clr_row + ROW_W'(1);
    end
  end

  // Current state and next-free value seen by an accepted beat
  assign cur_acc = at_root ? root_state : walk_state;
  assign nf_acc  = started ? next_free : first_free_state;

  always_ff @(posedge clk) begin
    if (accept) begin
      sym_q  <= item.symbol;
      pid_q  <= item.pattern_id;
      last_q <= item.last_symbol;
      cur_q  <= cur_acc;
      nf_q   <= nf_acc;
    end
  end

  ttb_edge_store #(
    .MAX_STATES(MAX_STATES),
    .ALPHABET  (ALPHABET)
  ) u_store (
    .clk      (clk),
    .cmd      (cmd),
    .rd_row   (ROW_W'(cur_acc)),
    .rd_col   (COL_W'(item.symbol)),
    .clr_row  (clr_row),
    .wr_target(wr_target),
    .hit      (hit),
    .target   (target)
  );

  // Decide the edge: follow, allocate or terminate; flag overflow
  always_comb begin
    sym_ok          = ({1'b0, sym_q} < 9'(ALPHABET));
    in_range        = (32'(cur_q) < MAX_STATES);
    to_v            = '0;
    alloc_v         = 1'b0;
    write_edge      = 1'b0;
    wr_target       = last_q ? pid_q : nf_q[ttb_pkg::STATE_W-1:0];
    grown           = {1'b0, nf_q};
    ovf_next        = ovf;
    walk_state_next = walk_state;
    at_root_next    = at_root;
    if (!ovf && sym_ok) begin
      if (!in_range) begin
        ovf_next = 1'b1;
      end else begin
        if (last_q) begin
          to_v         = pid_q;
          write_edge   = !hit;
          at_root_next = 1'b1;
        end else if (hit) begin
          to_v            = target;
          walk_state_next = target;
          at_root_next    = 1'b0;
        end else begin
          to_v            = nf_q[ttb_pkg::STATE_W-1:0];
          write_edge      = 1'b1;
          walk_state_next = nf_q[ttb_pkg::STATE_W-1:0];
          at_root_next    = 1'b0;
          alloc_v         = 1'b1;
          grown           = {1'b0, nf_q} + 12'd1;
        end
        if (grown > {1'b0, state_limit} || 32'(grown) > MAX_STATES) ovf_next = 1'b1;
      end
    end
    next_free_next = grown[ttb_pkg::FREE_W] ? ttb_pkg::FREE_MAX
                                            : grown[ttb_pkg::FREE_W-1:0];
  end

  // Update walk state and register the result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      walk_state <= '0;
      at_root    <= 1'b1;
      next_free  <= '0;
      started    <= 1'b0;
      ovf        <= 1'b0;
      done       <= 1'b0;
    end else begin
      done <= (state == ttb_pkg::ST_LOOK);
      if (accept) started <= 1'b1;
      if (state == ttb_pkg::ST_LOOK) begin
        walk_state <= walk_state_next;
        at_root    <= at_root_next;
        next_free  <= next_free_next;
        ovf        <= ovf_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ttb_pkg::ST_LOOK) begin
      result.from_state  <= cur_q;
      result.to_state    <= to_v;
      result.allocated   <= alloc_v;
      result.used_states <= next_free_next;
      result.overflow    <= ovf_next;
    end
  end

  // Checks
  `TTB_ASSERT_IMPLY(a_done_two_after_accept, clk, rst, 1'b1, done == $past(accept, 2))
  `TTB_ASSERT_NEXT(a_overflow_sticky, clk, rst, ovf, ovf)
  `TTB_ASSERT_IMPLY(a_no_edge_write_in_clear, clk, rst, cmd.clr, !cmd.wr_edge && busy)
  `TTB_ASSERT_IMPLY(a_alloc_counts, clk, rst, done && result.allocated,
                    result.used_states != '0 && !result.overflow || result.overflow)

endmodule

// ===== verif/trie_builder_checker.sv =====
// Checker for the trie transition builder: watches item, result and register beats.
// Keeps its own goto-table copy to predict each edge result. Depends on ttb_pkg.
`timescale 1ns / 1ps

module trie_builder_checker #(
  parameter int MAX_STATES = ttb_pkg::MAX_STATES_DEF,
  parameter int ALPHABET   = ttb_pkg::ALPHABET_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           busy,
  input  ttb_pkg::item_t                 item,
  input  logic                           done,
  input  ttb_pkg::result_t               result,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [ttb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ttb_pkg::FREE_W-1:0]     cfg_data,
  output int unsigned                    mismatches
);
  import ttb_pkg::*;

  // Register copies
  int unsigned root_reg;
  int unsigned first_free_reg;
  int unsigned limit_reg;

  // Walk state and goto table copy; a key present means its valid mark is set
  int unsigned goto_edges [int unsigned];
  int unsigned walk_id;
  bit          at_root;
  int unsigned free_id;
  bit          started;
  bit          ovf;

  result_t expected_edges [$];
  result_t want;

  // Apply one pattern byte to the table copy and return the edge it reports
  function automatic result_t advance_walk(item_t beat);
    result_t     r;
    int unsigned cur;
    int unsigned grown;
    int unsigned key;
    int unsigned lim;
    r = '0;
    if (!started) begin
      started = 1'b1;
      free_id = first_free_reg;
    end
    cur = at_root ? root_reg : walk_id;
    if (!ovf && beat.symbol < ALPHABET) begin
      if (cur >= MAX_STATES) begin
        ovf = 1'b1;
      end else begin
        grown = free_id;
        key   = cur * ALPHABET + beat.symbol;
        if (beat.last_symbol) begin
          // keep the first stored edge, still report the pattern id
          if (!goto_edges.exists(key)) goto_edges[key] = beat.pattern_id;
          r.to_state = beat.pattern_id;
          at_root = 1'b1;
        end else if (goto_edges.exists(key)) begin
          walk_id    = goto_edges[key];
          r.to_state = walk_id[STATE_W-1:0];
          at_root    = 1'b0;
        end else begin
          goto_edges[key] = free_id;
          walk_id     = free_id;
          r.to_state  = free_id[STATE_W-1:0];
          r.allocated = 1'b1;
          at_root     = 1'b0;
          grown       = free_id + 1;
        end
        // judge overflow before the counter saturates
        lim = (limit_reg > MAX_STATES) ? MAX_STATES : limit_reg;
        if (grown > lim) ovf = 1'b1;
        free_id = (grown > FREE_MAX) ? FREE_MAX : grown;
      end
    end
    r.from_state  = cur[STATE_W-1:0];
    r.used_states = free_id[FREE_W-1:0];
    r.overflow    = ovf;
    return r;
  endfunction

  task automatic flag_mismatch(string what, int unsigned exp_val, int unsigned got_val);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch, expected %0d got %0d", $time, what, exp_val, got_val);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mismatches     = 0;
      root_reg       = 0;
      first_free_reg = 1;
      limit_reg      = 1024;
      goto_edges.delete();
      walk_id  = 0;
      at_root  = 1'b1;
      free_id  = 0;
      started  = 1'b0;
      ovf      = 1'b0;
      expected_edges.delete();
    end else begin
      // Compare the result beat with the oldest prediction
      if (done) begin
        if (expected_edges.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result beat with nothing pending (from %0d to %0d)",
                     $time, result.from_state, result.to_state);
        end else begin
          want = expected_edges.pop_front();
          if (result.from_state !== want.from_state)
            flag_mismatch("from_state", want.from_state, result.from_state);
          if (result.to_state !== want.to_state)
            flag_mismatch("to_state", want.to_state, result.to_state);
          if (result.allocated !== want.allocated)
            flag_mismatch("allocated", want.allocated, result.allocated);
          if (result.used_states !== want.used_states)
            flag_mismatch("used_states", want.used_states, result.used_states);
          if (result.overflow !== want.overflow)
            flag_mismatch("overflow", want.overflow, result.overflow);
        end
      end
      // Track register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ROOT_STATE:  root_reg       = cfg_data[STATE_W-1:0];
          CFG_FIRST_FREE:  first_free_reg = cfg_data;
          CFG_STATE_LIMIT: limit_reg      = cfg_data;
          default: ;
        endcase
      end
      // Predict each accepted item beat
      if (start && !busy)
        expected_edges.insert(expected_edges.size(), advance_walk(item));
    end
  end

endmodule

// ===== verif/testbench.sv =====
// Top of the trie builder testbench: clock, reset, item and register stimulus.
// Instantiates trie_transition_builder_core and trie_builder_checker; uses ttb_pkg.
`timescale 1ns / 1ps

module testbench;
  import ttb_pkg::*;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  item_t                item;
  logic                 done;
  result_t              result;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [FREE_W-1:0]    cfg_data;

  int unsigned mismatches;
  int unsigned sent;
  int unsigned dones;
  int unsigned quiet_left;

  trie_transition_builder_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  trie_builder_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .item       (item),
    .done       (done),
    .result     (result),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Count result beats
  always @(posedge clk) begin
    if (rst) dones <= 0;
    else if (done) dones <= dones + 1;
  end

  // Hard stop in case the block hangs
  initial begin
    #3_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Write one register; hold valid until ready, then drop valid
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FREE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Drop start and hold until every result beat is back
  task automatic wait_drained();
    start <= 1'b0;
    while (dones != sent) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Random gap after a beat: mostly none or short, a few long, some quiet stretches
  task automatic idle_gap();
    int unsigned roll;
    int unsigned len;
    roll = $urandom_range(0, 99);
    if (quiet_left > 0) begin
      quiet_left--;
      return;
    end
    if (roll < 3) begin
      quiet_left = $urandom_range(10, 40);
      return;
    end
    if (roll < 5) begin
      wait_drained();
      return;
    end
    if (roll < 55) return;
    len = (roll < 92) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    start <= 1'b0;
    repeat (len) @(posedge clk);
  endtask

  // Present one byte beat and hold it until accepted
  task automatic send_byte(input logic [SYM_W-1:0] sym, input logic [STATE_W-1:0] pid,
                           input logic last);
    item_t beat;
    beat.symbol      = sym;
    beat.pattern_id  = pid;
    beat.last_symbol = last;
    start <= 1'b1;
    item  <= beat;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
    idle_gap();
  endtask

  // Mostly whole patterns over a narrow alphabet so prefixes are shared,
  // some over the full byte range, and loose bytes that break the walk
  task automatic run_patterns(input int unsigned quota, input int unsigned base);
    int unsigned count;
    int unsigned mix;
    int unsigned len;
    int unsigned pid;
    int unsigned sym;
    count = 0;
    while (count < quota) begin
      mix = $urandom_range(0, 99);
      pid = $urandom_range(1, 1023);
      if (mix < 10) begin
        send_byte(SYM_W'($urandom_range(0, 255)), STATE_W'(pid), 1'($urandom_range(0, 1)));
        count++;
      end else begin
        len = (mix < 25) ? $urandom_range(1, 4) : $urandom_range(1, 5);
        for (int k = 0; k < len; k++) begin
          sym = (mix < 25) ? $urandom_range(0, 255) : (base + $urandom_range(0, 2));
          send_byte(sym[SYM_W-1:0], STATE_W'(pid), k == len - 1);
        end
        count += len;
      end
    end
  endtask

  initial begin
    int unsigned guard;
    sent       = 0;
    quiet_left = 0;
    rst       <= 1'b1;
    start     <= 1'b0;
    item      <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_ROOT_STATE;
    cfg_data  <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Top root, allocation from zero; first_free only counts before the first item
    write_reg(CFG_ROOT_STATE, 11'h7FF);
    write_reg(CFG_FIRST_FREE, 11'd0);
    write_reg(CFG_STATE_LIMIT, 11'd1024);

    // Directed: single-byte pattern, repeat on an existing last-byte edge,
    // walk through an edge made by a last byte, shared prefixes, byte extremes
    send_byte(8'h00, 10'd1, 1'b1);
    send_byte(8'h00, 10'd2, 1'b1);
    send_byte(8'h00, 10'd3, 1'b0);
    send_byte(8'hFF, 10'd3, 1'b1);
    send_byte(8'hFF, 10'd1023, 1'b0);
    send_byte(8'h80, 10'd1023, 1'b0);
    send_byte(8'h7F, 10'd1023, 1'b1);
    send_byte(8'hFF, 10'd512, 1'b0);
    send_byte(8'h80, 10'd512, 1'b0);
    send_byte(8'h55, 10'd512, 1'b1);
    send_byte(8'hAA, 10'h155, 1'b1);
    send_byte(8'h01, 10'h2AA, 1'b0);
    send_byte(8'h02, 10'h2AA, 1'b0);
    send_byte(8'h03, 10'h2AA, 1'b1);
    wait_drained();

    // Root zero, limit above the table size
    write_reg(CFG_ROOT_STATE, 11'd0);
    write_reg(CFG_STATE_LIMIT, 11'h7FF);
    run_patterns(350, 0);
    wait_drained();

    // Mid root, late first_free write has no effect, limit at the table size
    write_reg(CFG_ROOT_STATE, FREE_W'($urandom_range(1, 1022)));
    write_reg(CFG_FIRST_FREE, 11'h7FF);
    write_reg(CFG_STATE_LIMIT, 11'd1024);
    run_patterns(350, 253);
    wait_drained();

    // Back to the top root with a random narrow alphabet
    write_reg(CFG_ROOT_STATE, 11'd1023);
    run_patterns(300, $urandom_range(0, 253));
    wait_drained();

    // Smallest limit: overflow trips and sticks
    write_reg(CFG_STATE_LIMIT, 11'd1);
    write_reg(CFG_ROOT_STATE, 11'd0);
    run_patterns(20, 0);

    // Let the last results come back
    start <= 1'b0;
    guard = 0;
    while (dones != sent && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);

    $display("Drove %0d pattern bytes over five register settings (roots 0 to 1023,", sent);
    $display("limits 1 to 2047, ending in sticky overflow); %0d edge results compared.", dones);
    if (mismatches == 0 && dones == sent) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/ttb_pkg.sv
src/ttb_edge_store.sv
src/trie_transition_builder_core.sv
verif/trie_builder_checker.sv
verif/testbench.sv
